[hw/rtl/tld_pkg.sv]
// ----------------------------------------------------------------------------
// tld_pkg
// Shared constants, beat types and state codes for the TIFF LZW decoder.
// ----------------------------------------------------------------------------
package tld_pkg;

	localparam int TLD_DICT_ENTRIES  = 4096;
	localparam int TLD_MAX_CODE_BITS = 12;
	localparam int STACK_DEPTH       = 4096;
	localparam int STK_AW            = 12;
	localparam int SP_W              = 13;
	localparam int CHUNK_BYTES       = 64;
	localparam int LANE_W            = 7;
	localparam int LEN_W             = 24;
	localparam int CW_W              = 4;
	localparam int BUF_W             = 20;
	localparam int HELD_W            = 5;
	localparam int CODE_CLEAR        = 256;
	localparam int CODE_END          = 257;
	localparam int FIRST_FREE        = 258;
	localparam int MIN_CODE_BITS     = 9;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_END_SEEN  = 2'd1,
		STAT_BAD_FIRST = 2'd2,
		STAT_LIMIT     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_WALK,
		S_PUSH,
		S_PREP,
		S_EMIT,
		S_FLUSH,
		S_END
	} fsm_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       segment_end;
	} in_t;

	typedef struct packed {
		logic [63:0]       lane_word0;
		logic [63:0]       lane_word1;
		logic [63:0]       lane_word2;
		logic [63:0]       lane_word3;
		logic [63:0]       lane_word4;
		logic [63:0]       lane_word5;
		logic [63:0]       lane_word6;
		logic [63:0]       lane_word7;
		logic [LANE_W-1:0] byte_count;
		logic              run_last;
		logic              segment_done;
		status_t           status;
	} out_t;

endpackage

[hw/rtl/tld_ram.sv]
// ----------------------------------------------------------------------------
// tld_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/tiff_lzw_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tiff_lzw_decoder_unit
// TIFF LZW decoder, 9 to 12 bit codes with early change. One compressed byte
// per input beat; each decoded string leaves in beats of up to 64 bytes.
//
// One input beat is taken at a time. A byte that completes no code passes
// through the end state, which flushes a beat when it ends the segment. A
// byte that completes a string code is expanded by walking its dictionary
// chain (one dictionary RAM read per cycle), then emitted in output beats of
// up to 64 bytes (one stack RAM read per cycle while the beat has room), and
// the output side can stall. Clear, end and rejected codes go to the end state.
// ----------------------------------------------------------------------------
module tiff_lzw_decoder_unit
	import tld_pkg::*;
#(
	parameter int DICT_ENTRIES  = TLD_DICT_ENTRIES,
	parameter int MAX_CODE_BITS = TLD_MAX_CODE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(DICT_ENTRIES);
	localparam int NF_W   = IDX_W + 1;
	localparam int CODE_W = MAX_CODE_BITS;
	localparam int CUR_W  = (IDX_W > CODE_W) ? IDX_W : CODE_W;
	localparam int CMP_W  = ((NF_W > CODE_W) ? NF_W : CODE_W) + 1;
	localparam int DW     = IDX_W + 8;

	fsm_t state_q, state_d;

	logic [LEN_W-1:0]  exp_q, bytes_q, rem_q;
	logic [NF_W-1:0]   nf_q;
	logic [CW_W-1:0]   cw_q;
	logic [IDX_W-1:0]  prev_q;
	logic              prev_none_q;
	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] bits_q;
	logic              stop_q;
	status_t           reason_q;
	logic              seg_end_q, was_stop_q, kw_q, first_path_q;
	logic [CODE_W-1:0] code_q;
	logic [CUR_W-1:0]  cur_q;
	logic [SP_W-1:0]   sp_q, cnt_q;
	logic [7:0]        first_q;
	logic [STK_AW-1:0] rd_ptr_q;
	logic [LANE_W-1:0] lane_q;
	logic              pend_s1;
	logic [5:0]        lane_s1;
	logic [CHUNK_BYTES*8-1:0] chunk_q;
	logic              out_valid_q;
	out_t              out_q;

	logic              accept;
	logic [BUF_W-1:0]  buf_new, shifted;
	logic [HELD_W-1:0] bits_new, code_sh;
	logic [CODE_W-1:0] ones_sh, code_new;
	logic              code_ready;
	logic [CUR_W-1:0]  code_ext, cur_start;
	logic              kw, walk_go, walk_more, dict_full, cw_up;
	logic [NF_W-1:0]   nf_inc;
	logic [SP_W-1:0]   sp_inc, cnt_new;
	logic [LEN_W-1:0]  rem_new, sp_len;
	logic              halt_len, issue, can_load, need_empty, out_load, seg_clear;

	logic              dict_we;
	logic [IDX_W-1:0]  dict_waddr, dict_raddr;
	logic [DW-1:0]     dict_wdata, dict_rdata;
	logic [IDX_W-1:0]  prefix_rd;
	logic [7:0]        suffix_rd;
	logic              stk_we;
	logic [STK_AW-1:0] stk_waddr;
	logic [7:0]        stk_wdata, stk_rdata;

	tld_ram #(.WIDTH(DW), .DEPTH(DICT_ENTRIES)) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.raddr (dict_raddr),
		.rdata (dict_rdata)
	);

	tld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (rd_ptr_q),
		.rdata (stk_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign prefix_rd = dict_rdata[DW-1:8];
	assign suffix_rd = dict_rdata[7:0];

	always_comb begin
		buf_new    = {buf_q[BUF_W-9:0], in_data.data_byte};
		bits_new   = bits_q + HELD_W'(8);
		code_ready = bits_new >= HELD_W'(cw_q);
		code_sh    = bits_new - HELD_W'(cw_q);
		shifted    = buf_new >> code_sh;
		ones_sh    = {CODE_W{1'b1}} << cw_q;
		code_new   = shifted[CODE_W-1:0] & ~ones_sh;

		code_ext   = CUR_W'(code_q);
		kw         = CMP_W'(code_q) >= CMP_W'(nf_q);
		cur_start  = kw ? CUR_W'(prev_q) : code_ext;
		walk_go    = cur_start >= CUR_W'(CODE_CLEAR);
		sp_inc     = sp_q + SP_W'(1);
		walk_more  = (CUR_W'(prefix_rd) >= CUR_W'(CODE_CLEAR)) &&
		             (sp_inc < SP_W'(STACK_DEPTH - 1));

		dict_full  = nf_q >= NF_W'(DICT_ENTRIES);
		nf_inc     = dict_full ? nf_q : nf_q + NF_W'(1);
		cw_up      = (CMP_W'(nf_inc) + CMP_W'(1) >= (CMP_W'(1) << cw_q)) &&
		             (cw_q < CW_W'(MAX_CODE_BITS));
		rem_new    = (exp_q > bytes_q) ? exp_q - bytes_q : '0;

		sp_len     = LEN_W'(sp_q);
		halt_len   = sp_len >= rem_q;
		cnt_new    = halt_len ? SP_W'(rem_q) : sp_q;

		issue      = (cnt_q != '0) && (lane_q != LANE_W'(CHUNK_BYTES));
		can_load   = !out_valid_q || out_ready;
		need_empty = seg_end_q || (stop_q && !was_stop_q);
	end

	always_comb begin
		dict_we    = (state_q == S_PUSH) && !first_path_q && !dict_full;
		dict_waddr = nf_q[IDX_W-1:0];
		dict_wdata = {prev_q, cur_q[7:0]};
		dict_raddr = (state_q == S_DEC) ? cur_start[IDX_W-1:0] : prefix_rd;

		stk_we    = 1'b0;
		stk_waddr = sp_q[STK_AW-1:0];
		stk_wdata = cur_q[7:0];
		case (state_q)
			S_WALK: begin
				stk_we    = 1'b1;
				stk_wdata = suffix_rd;
			end
			S_PUSH: begin
				stk_we = 1'b1;
			end
			S_PREP: begin
				stk_we    = kw_q;
				stk_waddr = '0;
				stk_wdata = first_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		seg_clear = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (!stop_q && code_ready) ? S_DEC : S_END;
				end
			end
			S_DEC: begin
				if (code_ext == CUR_W'(CODE_END) || code_ext == CUR_W'(CODE_CLEAR)) begin
					state_d = S_END;
				end else if (prev_none_q) begin
					state_d = (code_ext >= CUR_W'(CODE_CLEAR)) ? S_END : S_PUSH;
				end else begin
					state_d = walk_go ? S_WALK : S_PUSH;
				end
			end
			S_WALK: begin
				state_d = walk_more ? S_WALK : S_PUSH;
			end
			S_PUSH: begin
				state_d = S_PREP;
			end
			S_PREP: begin
				state_d = (cnt_new != '0) ? S_EMIT : S_END;
			end
			S_EMIT: begin
				if (!issue && !pend_s1) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (can_load) begin
					out_load = 1'b1;
					if (cnt_q == '0) begin
						state_d   = S_IDLE;
						seg_clear = seg_end_q;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_END: begin
				if (need_empty) begin
					state_d = S_FLUSH;
				end else begin
					state_d   = S_IDLE;
					seg_clear = seg_end_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q        <= '0;
			bytes_q      <= '0;
			rem_q        <= '0;
			nf_q         <= NF_W'(FIRST_FREE);
			cw_q         <= CW_W'(MIN_CODE_BITS);
			prev_q       <= '0;
			prev_none_q  <= 1'b1;
			buf_q        <= '0;
			bits_q       <= '0;
			stop_q       <= 1'b0;
			reason_q     <= STAT_OK;
			seg_end_q    <= 1'b0;
			was_stop_q   <= 1'b0;
			kw_q         <= 1'b0;
			first_path_q <= 1'b0;
			code_q       <= '0;
			cur_q        <= '0;
			sp_q         <= '0;
			cnt_q        <= '0;
			first_q      <= '0;
			rd_ptr_q     <= '0;
			lane_q       <= '0;
			pend_s1      <= 1'b0;
			lane_s1      <= '0;
			chunk_q      <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				exp_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						seg_end_q  <= in_data.segment_end;
						was_stop_q <= stop_q;
						if (!stop_q) begin
							buf_q <= buf_new;
							if (code_ready) begin
								bits_q <= code_sh;
								code_q <= code_new;
							end else begin
								bits_q <= bits_new;
							end
						end
					end
				end
				S_DEC: begin
					kw_q         <= 1'b0;
					first_path_q <= 1'b0;
					sp_q         <= '0;
					cur_q        <= code_ext;
					if (code_ext == CUR_W'(CODE_END)) begin
						stop_q   <= 1'b1;
						reason_q <= STAT_END_SEEN;
					end else if (code_ext == CUR_W'(CODE_CLEAR)) begin
						nf_q        <= NF_W'(FIRST_FREE);
						cw_q        <= CW_W'(MIN_CODE_BITS);
						prev_none_q <= 1'b1;
					end else if (prev_none_q) begin
						first_path_q <= 1'b1;
						if (code_ext >= CUR_W'(CODE_CLEAR)) begin
							stop_q   <= 1'b1;
							reason_q <= STAT_BAD_FIRST;
						end
					end else begin
						kw_q  <= kw;
						sp_q  <= kw ? SP_W'(1) : '0;
						cur_q <= cur_start;
					end
				end
				S_WALK: begin
					sp_q  <= sp_inc;
					cur_q <= CUR_W'(prefix_rd);
				end
				S_PUSH: begin
					first_q <= cur_q[7:0];
					sp_q    <= sp_inc;
					rem_q   <= rem_new;
					if (first_path_q) begin
						prev_q      <= cur_q[IDX_W-1:0];
						prev_none_q <= 1'b0;
					end else begin
						nf_q <= nf_inc;
						if (cw_up) begin
							cw_q <= cw_q + CW_W'(1);
						end
						if (!kw_q) begin
							prev_q <= code_q[IDX_W-1:0];
						end else if (!dict_full) begin
							prev_q <= nf_q[IDX_W-1:0];
						end
					end
				end
				S_PREP: begin
					cnt_q    <= cnt_new;
					bytes_q  <= bytes_q + LEN_W'(cnt_new);
					rd_ptr_q <= STK_AW'(sp_q - SP_W'(1));
					lane_q   <= '0;
					pend_s1  <= 1'b0;
					chunk_q  <= '0;
					if (halt_len) begin
						stop_q   <= 1'b1;
						reason_q <= STAT_LIMIT;
					end
				end
				S_EMIT: begin
					pend_s1 <= issue;
					lane_s1 <= lane_q[5:0];
					if (issue) begin
						rd_ptr_q <= rd_ptr_q - STK_AW'(1);
						cnt_q    <= cnt_q - SP_W'(1);
						lane_q   <= lane_q + LANE_W'(1);
					end
					if (pend_s1) begin
						chunk_q[lane_s1*8 +: 8] <= stk_rdata;
					end
				end
				S_FLUSH: begin
					if (out_load) begin
						out_q.lane_word0   <= chunk_q[63:0];
						out_q.lane_word1   <= chunk_q[127:64];
						out_q.lane_word2   <= chunk_q[191:128];
						out_q.lane_word3   <= chunk_q[255:192];
						out_q.lane_word4   <= chunk_q[319:256];
						out_q.lane_word5   <= chunk_q[383:320];
						out_q.lane_word6   <= chunk_q[447:384];
						out_q.lane_word7   <= chunk_q[511:448];
						out_q.byte_count   <= lane_q;
						out_q.run_last     <= (cnt_q == '0);
						out_q.segment_done <= (cnt_q == '0) && seg_end_q;
						out_q.status       <= stop_q ? reason_q : STAT_OK;
						chunk_q            <= '0;
						lane_q             <= '0;
					end
				end
				S_END: begin
					chunk_q <= '0;
					lane_q  <= '0;
					cnt_q   <= '0;
				end
				default: begin
				end
			endcase

			if (seg_clear) begin
				nf_q        <= NF_W'(FIRST_FREE);
				cw_q        <= CW_W'(MIN_CODE_BITS);
				prev_none_q <= 1'b1;
				buf_q       <= '0;
				bits_q      <= '0;
				bytes_q     <= '0;
				stop_q      <= 1'b0;
				reason_q    <= STAT_OK;
			end
		end
	end

	// chain walk is only ever entered from a fresh code or continues itself
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> $past(state_q) == S_DEC || $past(state_q) == S_WALK)
		else $error("chain walk entered from wrong state");

	a_dict_room: assert property (@(posedge clk) disable iff (!arst_n)
		dict_we |-> nf_q < NF_W'(DICT_ENTRIES) && !prev_none_q)
		else $error("dictionary write with no free entry");

	a_beat_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid && out_data.byte_count <= LANE_W'(CHUNK_BYTES))
		else $error("output beat overfilled");

	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		cw_q >= CW_W'(MIN_CODE_BITS) && cw_q <= CW_W'(MAX_CODE_BITS))
		else $error("code width out of range");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q) == S_EMIT)
		else $error("stack read in flight outside emission");

endmodule
